[rtl/core/crl_pkg.sv]
// Shared constants and types for the clipped line rasterizer.
package crl_pkg;

    localparam int COORD_BITS   = 12;
    localparam int DIM_BITS     = 12;
    localparam int ADDR_BITS    = 22;
    localparam int COLOUR_BITS  = 32;
    localparam int DELTA_BITS   = COORD_BITS + 1;
    localparam int ERR_BITS     = COORD_BITS + 2;
    localparam int ERR_SUM_BITS = COORD_BITS + 4;
    localparam int CMP_BITS     = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
    localparam int PROD_BITS    = (COORD_BITS + DIM_BITS > ADDR_BITS) ?
                                  (COORD_BITS + DIM_BITS) : ADDR_BITS;

    // Queue depth must stay a power of two so the pointers wrap by themselves.
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = 1;

    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BUFFER_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BUFFER_HEIGHT = 1'd1;

    localparam logic [DIM_BITS-1:0] BUFFER_WIDTH_RESET  = 12'd320;
    localparam logic [DIM_BITS-1:0] BUFFER_HEIGHT_RESET = 12'd240;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    typedef struct packed {
        logic                          is_step;
        logic                          steep;
        logic                          minor_dir;
        logic signed [COORD_BITS-1:0]  major_pos;
        logic signed [COORD_BITS-1:0]  minor_pos;
        logic [DELTA_BITS-1:0]         major_delta;
        logic [DELTA_BITS-1:0]         minor_delta;
        logic [COLOUR_BITS-1:0]        colour;
    } q_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  x;
        logic signed [COORD_BITS-1:0]  y;
        logic [COLOUR_BITS-1:0]        colour;
        logic                          last;
        logic                          line_pix;
    } pix_t;

endpackage

[rtl/core/crl_front.sv]
// Front end: accepts requests, sets up start requests and queues them.
module crl_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   req_type,
    input  logic signed [crl_pkg::COORD_BITS-1:0]  start_x,
    input  logic signed [crl_pkg::COORD_BITS-1:0]  start_y,
    input  logic signed [crl_pkg::COORD_BITS-1:0]  end_x,
    input  logic signed [crl_pkg::COORD_BITS-1:0]  end_y,
    input  logic [crl_pkg::COLOUR_BITS-1:0]        line_colour,
    input  logic                                   q_pop,
    output logic                                   q_valid,
    output crl_pkg::q_item_t                       q_item
);

    logic                                    swap;
    logic signed [crl_pkg::COORD_BITS-1:0]   lx, ly, rx, ry;
    logic signed [crl_pkg::DELTA_BITS-1:0]   dx, dy;
    logic [crl_pkg::DELTA_BITS-1:0]          adx, ady;
    logic                                    steep;
    crl_pkg::q_item_t                        item;

    crl_pkg::q_item_t                        mem_reg [crl_pkg::QUEUE_DEPTH];
    logic [crl_pkg::QUEUE_PTR_BITS-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [crl_pkg::QUEUE_PTR_BITS-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [crl_pkg::QUEUE_PTR_BITS:0]        count_reg, count_next;
    logic                                    push;

    // Order endpoints so x rises, then pick the major axis.
    always_comb
    begin
        swap = start_x > end_x;
        lx   = swap ? end_x : start_x;
        ly   = swap ? end_y : start_y;
        rx   = swap ? start_x : end_x;
        ry   = swap ? start_y : end_y;
        dx   = crl_pkg::DELTA_BITS'(rx) - crl_pkg::DELTA_BITS'(lx);
        dy   = crl_pkg::DELTA_BITS'(ry) - crl_pkg::DELTA_BITS'(ly);
        adx  = dx;
        ady  = (dy < 0) ? crl_pkg::DELTA_BITS'(-dy) : crl_pkg::DELTA_BITS'(dy);
        steep = ady > adx;

        item.is_step     = (req_type == crl_pkg::REQ_STEP);
        item.steep       = steep;
        item.minor_dir   = dy < 0;
        item.major_pos   = steep ? ly : lx;
        item.minor_pos   = steep ? lx : ly;
        item.major_delta = steep ? ady : adx;
        item.minor_delta = steep ? adx : ady;
        item.colour      = line_colour;
    end

    assign in_stall = (count_reg == (crl_pkg::QUEUE_PTR_BITS + 1)'(crl_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + (crl_pkg::QUEUE_PTR_BITS + 1)'(1);
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - (crl_pkg::QUEUE_PTR_BITS + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

[rtl/core/crl_back.sv]
// Back end: holds the line state and advances the Bresenham walk.
module crl_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  crl_pkg::q_item_t  q_item,
    output logic              q_pop,
    input  logic              pix_ready,
    output logic              pix_valid,
    output crl_pkg::pix_t     pix
);

    logic                                     active_reg, active_next;
    logic signed [crl_pkg::COORD_BITS-1:0]    major_reg, major_next;
    logic signed [crl_pkg::COORD_BITS-1:0]    minor_reg, minor_next;
    logic signed [crl_pkg::ERR_BITS-1:0]      err_reg, err_next;
    logic [crl_pkg::DELTA_BITS-1:0]           steps_reg, steps_next;
    logic [crl_pkg::DELTA_BITS-1:0]           major_delta_reg, major_delta_next;
    logic [crl_pkg::DELTA_BITS-1:0]           minor_delta_reg, minor_delta_next;
    logic                                     dir_reg, dir_next;
    logic                                     steep_reg, steep_next;
    logic [crl_pkg::COLOUR_BITS-1:0]          colour_reg, colour_next;

    logic signed [crl_pkg::ERR_SUM_BITS-1:0]  err_sum;
    logic signed [crl_pkg::ERR_SUM_BITS-1:0]  major_ext;
    logic signed [crl_pkg::ERR_SUM_BITS-1:0]  minor_ext;
    logic                                     minor_move;

    assign q_pop     = q_valid && pix_ready;
    assign pix_valid = q_pop;

    always_comb
    begin
        active_next      = active_reg;
        major_next       = major_reg;
        minor_next       = minor_reg;
        err_next         = err_reg;
        steps_next       = steps_reg;
        major_delta_next = major_delta_reg;
        minor_delta_next = minor_delta_reg;
        dir_next         = dir_reg;
        steep_next       = steep_reg;
        colour_next      = colour_reg;

        major_ext  = $signed(crl_pkg::ERR_SUM_BITS'(major_delta_reg));
        minor_ext  = $signed(crl_pkg::ERR_SUM_BITS'(minor_delta_reg));
        err_sum    = crl_pkg::ERR_SUM_BITS'(err_reg) + (minor_ext <<< 1);
        minor_move = err_sum >= major_ext;

        pix = '0;
        pix.last = 1'b1;

        if (q_pop)
        begin
            if (!q_item.is_step)
            begin
                major_next       = q_item.major_pos;
                minor_next       = q_item.minor_pos;
                err_next         = '0;
                steps_next       = q_item.major_delta;
                major_delta_next = q_item.major_delta;
                minor_delta_next = q_item.minor_delta;
                dir_next         = q_item.minor_dir;
                steep_next       = q_item.steep;
                colour_next      = q_item.colour;
                active_next      = (q_item.major_delta != '0);
            end
            else if (active_reg)
            begin
                if (steep_reg && dir_reg)
                begin
                    major_next = major_reg - crl_pkg::COORD_BITS'(1);
                end
                else
                begin
                    major_next = major_reg + crl_pkg::COORD_BITS'(1);
                end
                err_next = crl_pkg::ERR_BITS'(err_sum);
                if (minor_move)
                begin
                    err_next = crl_pkg::ERR_BITS'(err_sum - (major_ext <<< 1));
                    if (!steep_reg && dir_reg)
                    begin
                        minor_next = minor_reg - crl_pkg::COORD_BITS'(1);
                    end
                    else
                    begin
                        minor_next = minor_reg + crl_pkg::COORD_BITS'(1);
                    end
                end
                steps_next  = steps_reg - crl_pkg::DELTA_BITS'(1);
                active_next = (steps_reg != crl_pkg::DELTA_BITS'(1));
            end

            // Step with no line: emit a zero pixel with only last set.
            if (!q_item.is_step || active_reg)
            begin
                pix.x        = steep_next ? minor_next : major_next;
                pix.y        = steep_next ? major_next : minor_next;
                pix.colour   = colour_next;
                pix.last     = !active_next;
                pix.line_pix = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        major_reg       <= major_next;
        minor_reg       <= minor_next;
        err_reg         <= err_next;
        steps_reg       <= steps_next;
        major_delta_reg <= major_delta_next;
        minor_delta_reg <= minor_delta_next;
        dir_reg         <= dir_next;
        steep_reg       <= steep_next;
        colour_reg      <= colour_next;
    end

endmodule

[rtl/core/crl_out.sv]
// Output pipeline: clips the pixel, forms its address and holds the result.
module crl_out (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   pix_valid,
    input  crl_pkg::pix_t                          pix,
    output logic                                   pix_ready,
    input  logic [crl_pkg::DIM_BITS-1:0]           buffer_width,
    input  logic [crl_pkg::DIM_BITS-1:0]           buffer_height,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [crl_pkg::COORD_BITS-1:0]  pixel_x,
    output logic signed [crl_pkg::COORD_BITS-1:0]  pixel_y,
    output logic [crl_pkg::ADDR_BITS-1:0]          pixel_address,
    output logic [crl_pkg::COLOUR_BITS-1:0]        pixel_colour,
    output logic                                   write_enable,
    output logic                                   last_pixel
);

    logic                                a_valid_reg, a_valid_next;
    crl_pkg::pix_t                       a_pix_reg;
    logic                                b_valid_reg, b_valid_next;
    logic                                b_ready;

    logic [crl_pkg::COORD_BITS-1:0]      x_u, y_u;
    logic                                in_bounds;
    logic [crl_pkg::PROD_BITS-1:0]       prod;
    logic [crl_pkg::ADDR_BITS-1:0]       addr;

    logic signed [crl_pkg::COORD_BITS-1:0]  x_reg, y_reg;
    logic [crl_pkg::ADDR_BITS-1:0]          addr_reg;
    logic [crl_pkg::COLOUR_BITS-1:0]        colour_reg;
    logic                                   we_reg, last_reg;

    assign b_ready   = !b_valid_reg || !out_stall;
    assign pix_ready = !a_valid_reg || b_ready;

    always_comb
    begin
        x_u       = a_pix_reg.x;
        y_u       = a_pix_reg.y;
        in_bounds = a_pix_reg.line_pix && (a_pix_reg.x >= 0) && (a_pix_reg.y >= 0) &&
                    (crl_pkg::CMP_BITS'(x_u) < crl_pkg::CMP_BITS'(buffer_width)) &&
                    (crl_pkg::CMP_BITS'(y_u) < crl_pkg::CMP_BITS'(buffer_height));
        prod      = crl_pkg::PROD_BITS'(y_u) * crl_pkg::PROD_BITS'(buffer_width) +
                    crl_pkg::PROD_BITS'(x_u);
        addr      = in_bounds ? prod[crl_pkg::ADDR_BITS-1:0] : '0;

        a_valid_next = pix_ready ? pix_valid : a_valid_reg;
        b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_ready)
        begin
            a_pix_reg <= pix;
        end
        if (b_ready)
        begin
            x_reg      <= a_pix_reg.x;
            y_reg      <= a_pix_reg.y;
            addr_reg   <= addr;
            colour_reg <= a_pix_reg.colour;
            we_reg     <= in_bounds;
            last_reg   <= a_pix_reg.last;
        end
    end

    assign out_valid     = b_valid_reg;
    assign pixel_x       = x_reg;
    assign pixel_y       = y_reg;
    assign pixel_address = addr_reg;
    assign pixel_colour  = colour_reg;
    assign write_enable  = we_reg;
    assign last_pixel    = last_reg;

endmodule

[rtl/core/clipped_line_rasterizer.sv]
// Top level of the clipped line rasterizer: config registers and unit wiring.
//
//  channel  | handshake            | carries
//  ---------+----------------------+-----------------------------------------------
//  in       | in_valid / in_stall  | req_type, start_x, start_y, end_x, end_y, colour
//  out      | out_valid / out_stall| pixel_x, pixel_y, pixel_address, colour, flags
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// One transaction in per cycle and one pixel out per cycle unless stalled; the error
// term update in the back end (add, compare, subtract) lets steps run back to back.
// Input to output, a transaction passes the queue, clip stage and output register.
// A two-entry queue sits between front and back; in_stall rises only when it is full.
// Reset clears the queue, the pipeline valids and the active-line flag; width and
// height return to 320 and 240.
module clipped_line_rasterizer (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   req_type,
    input  logic signed [crl_pkg::COORD_BITS-1:0]  start_x,
    input  logic signed [crl_pkg::COORD_BITS-1:0]  start_y,
    input  logic signed [crl_pkg::COORD_BITS-1:0]  end_x,
    input  logic signed [crl_pkg::COORD_BITS-1:0]  end_y,
    input  logic [crl_pkg::COLOUR_BITS-1:0]        line_colour,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [crl_pkg::COORD_BITS-1:0]  pixel_x,
    output logic signed [crl_pkg::COORD_BITS-1:0]  pixel_y,
    output logic [crl_pkg::ADDR_BITS-1:0]          pixel_address,
    output logic [crl_pkg::COLOUR_BITS-1:0]        pixel_colour,
    output logic                                   write_enable,
    output logic                                   last_pixel,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [crl_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [crl_pkg::DIM_BITS-1:0]           cfg_data
);

    logic [crl_pkg::DIM_BITS-1:0]  width_reg, width_next;
    logic [crl_pkg::DIM_BITS-1:0]  height_reg, height_next;

    logic              q_valid;
    logic              q_pop;
    crl_pkg::q_item_t  q_item;
    logic              pix_valid;
    logic              pix_ready;
    crl_pkg::pix_t     pix;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                crl_pkg::CFG_BUFFER_WIDTH:  width_next  = cfg_data;
                crl_pkg::CFG_BUFFER_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= crl_pkg::BUFFER_WIDTH_RESET;
            height_reg <= crl_pkg::BUFFER_HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    crl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .line_colour (line_colour),
        .q_pop       (q_pop),
        .q_valid     (q_valid),
        .q_item      (q_item)
    );

    crl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .pix_ready (pix_ready),
        .pix_valid (pix_valid),
        .pix       (pix)
    );

    crl_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .pix_valid     (pix_valid),
        .pix           (pix),
        .pix_ready     (pix_ready),
        .buffer_width  (width_reg),
        .buffer_height (height_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_address (pixel_address),
        .pixel_colour  (pixel_colour),
        .write_enable  (write_enable),
        .last_pixel    (last_pixel)
    );

endmodule
